/* design/half_pel_image_interpolator_defines.svh */
// Assertion macros shared by the half-pel interpolator modules.
`ifndef HALF_PEL_IMAGE_INTERPOLATOR_DEFINES_SVH
`define HALF_PEL_IMAGE_INTERPOLATOR_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define HPI_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define HPI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/hpi_pkg.sv */
// Shared constants, types and averaging functions of the half-pel interpolator.
package hpi_pkg;

  localparam int PIX_W          = 8;
  localparam int COORD_W        = 10;
  localparam int CFG_W          = 11;
  localparam int CFG_IDX_W      = 1;
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int QUEUE_DEPTH    = 4;

  localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 11'd352;
  localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 11'd288;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  // Result kinds of one pixel, in emission order
  localparam int NUM_KINDS = 4;
  typedef logic [NUM_KINDS-1:0] kind_mask_t;
  localparam kind_mask_t KIND_UPPER_LEFT  = 4'b0001; // block of (row-1, col-1)
  localparam kind_mask_t KIND_UPPER_RIGHT = 4'b0010; // block of (row-1, col)
  localparam kind_mask_t KIND_LOWER_LEFT  = 4'b0100; // block of (row, col-1)
  localparam kind_mask_t KIND_LOWER_RIGHT = 4'b1000; // block of (row, col)
  localparam kind_mask_t KIND_ALL         = 4'b1111;

  // Neighborhood of one pixel as handed from front to back
  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [PIX_W-1:0] above;
    logic [PIX_W-1:0] left;
    logic [PIX_W-1:0] upper_left;
  } pix_quad_t;

  function automatic logic [PIX_W-1:0] avg2(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b);
    logic [PIX_W:0] s;
    s = (PIX_W+1)'(a) + (PIX_W+1)'(b) + (PIX_W+1)'(1);
    return s[PIX_W:1];
  endfunction

  function automatic logic [PIX_W-1:0] avg4(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b,
                                            input logic [PIX_W-1:0] c,
                                            input logic [PIX_W-1:0] d);
    logic [PIX_W+1:0] s;
    s = (PIX_W+2)'(a) + (PIX_W+2)'(b) + (PIX_W+2)'(c) + (PIX_W+2)'(d)
        + (PIX_W+2)'(2);
    return s[PIX_W+1:2];
  endfunction

endpackage

/* design/half_pel_image_interpolator.sv */
// Half-pel interpolator: takes one luma pixel per transfer in raster order and returns the
// 2x2 half-pel block (pixel, right, down and diagonal rounded averages) of every source pixel,
// one block per output transfer. The front end accepts a pixel every cycle while in_stall is
// low: it reads the pixel above from the line store (one RAM access per pixel, read and write
// at the same address) and classifies which blocks the pixel completes. A four-entry queue
// feeds the back end, which emits one block per cycle while out_stall is low. Blocks of row
// r-1 leave while row r arrives. The top row and the first pixel of each other row yield no
// block; inside the frame a pixel yields one, so throughput is one pixel per cycle when no
// stall holds it. Below the top row the last column yields two, the last row yields two per
// pixel after its first and the bottom-right pixel four; these pixels are bound by the output
// port at one block per cycle.
// Writing frame_width or frame_height restarts the frame at its top-left pixel; sizes below 2
// act as 2 and sizes above MAX_WIDTH or MAX_HEIGHT act as that limit.
module half_pel_image_interpolator #(
  parameter int MAX_WIDTH  = hpi_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = hpi_pkg::DEF_MAX_HEIGHT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [hpi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hpi_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [hpi_pkg::PIX_W-1:0]     in_pixel,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [hpi_pkg::COORD_W-1:0]   out_src_col,
  output logic [hpi_pkg::COORD_W-1:0]   out_src_row,
  output logic [hpi_pkg::PIX_W-1:0]     out_full_pel,
  output logic [hpi_pkg::PIX_W-1:0]     out_half_right,
  output logic [hpi_pkg::PIX_W-1:0]     out_half_down,
  output logic [hpi_pkg::PIX_W-1:0]     out_half_diag,
  output logic                          out_last_of_run,
  output logic                          out_frame_end
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int QW   = $bits(hpi_pkg::pix_quad_t) + hpi_pkg::NUM_KINDS + CW + RW;

  logic                f_push, q_full, q_pop, q_not_empty;
  hpi_pkg::pix_quad_t  f_quad, b_quad;
  hpi_pkg::kind_mask_t f_mask, b_mask;
  logic [CW-1:0]       f_col, b_col;
  logic [RW-1:0]       f_row, b_row;
  logic [QW-1:0]       q_wdata, q_rdata;

  hpi_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_pixel  (in_pixel),
    .q_full    (q_full),
    .q_push    (f_push),
    .q_quad    (f_quad),
    .q_mask    (f_mask),
    .q_col     (f_col),
    .q_row     (f_row)
  );

  // Pack and unpack queue entries
  assign q_wdata = {f_quad, f_mask, f_col, f_row};
  assign {b_quad, b_mask, b_col, b_row} = q_rdata;

  hpi_queue #(
    .WIDTH (QW),
    .DEPTH (hpi_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_push),
    .wdata     (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .rdata     (q_rdata),
    .not_empty (q_not_empty)
  );

  hpi_back #(
    .CW (CW),
    .RW (RW)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_not_empty     (q_not_empty),
    .q_pop           (q_pop),
    .q_quad          (b_quad),
    .q_mask          (b_mask),
    .q_col           (b_col),
    .q_row           (b_row),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_src_col     (out_src_col),
    .out_src_row     (out_src_row),
    .out_full_pel    (out_full_pel),
    .out_half_right  (out_half_right),
    .out_half_down   (out_half_down),
    .out_half_diag   (out_half_diag),
    .out_last_of_run (out_last_of_run),
    .out_frame_end   (out_frame_end)
  );

endmodule

/* design/hpi_ram.sv */
// Generic single-port RAM with read-before-write and registered read data.
module hpi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Read old contents, then write
  always_ff @(posedge clk) begin
    if (en) begin
      rdata_r <= mem[addr];
      if (we) begin
        mem[addr] <= wdata;
      end
    end
  end

  assign rdata = rdata_r;

endmodule

/* design/hpi_front.sv */
// Front end: frame registers, raster counters, line store and result classification.
`include "half_pel_image_interpolator_defines.svh"

module hpi_front #(
  parameter int MAX_WIDTH  = hpi_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = hpi_pkg::DEF_MAX_HEIGHT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [hpi_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hpi_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [hpi_pkg::PIX_W-1:0]         in_pixel,
  input  logic                              q_full,
  output logic                              q_push,
  output hpi_pkg::pix_quad_t                q_quad,
  output hpi_pkg::kind_mask_t               q_mask,
  output logic [$clog2(MAX_WIDTH)-1:0]      q_col,
  output logic [$clog2(MAX_HEIGHT)-1:0]     q_row
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int WSZ = (hpi_pkg::CFG_W > $clog2(MAX_WIDTH + 1)) ?
                       hpi_pkg::CFG_W : $clog2(MAX_WIDTH + 1);
  localparam int HSZ = (hpi_pkg::CFG_W > $clog2(MAX_HEIGHT + 1)) ?
                       hpi_pkg::CFG_W : $clog2(MAX_HEIGHT + 1);

  logic [hpi_pkg::CFG_W-1:0] frame_width_r, frame_height_r;
  logic [CW-1:0]             col_r, col_nxt, w_last;
  logic [RW-1:0]             row_r, row_nxt, h_last;
  logic [WSZ-1:0]            w_ext;
  logic [HSZ-1:0]            h_ext;
  logic                      last_col, last_row, in_acc;

  logic                      s2_valid_r;
  logic [hpi_pkg::PIX_W-1:0] s2_pix_r;
  logic [CW-1:0]             s2_col_r;
  logic [RW-1:0]             s2_row_r;
  logic                      s2_last_col_r, s2_last_row_r;
  logic                      s2_advance, s2_corner;
  hpi_pkg::kind_mask_t       s2_mask;
  logic [hpi_pkg::PIX_W-1:0] above;
  logic [hpi_pkg::PIX_W-1:0] left_r, upper_left_r;

  // Clamp frame size to the supported range and form the last index
  always_comb begin
    w_ext = WSZ'(frame_width_r);
    h_ext = HSZ'(frame_height_r);
    if (w_ext < WSZ'(2)) begin
      w_last = CW'(1);
    end else if (w_ext > WSZ'(MAX_WIDTH)) begin
      w_last = CW'(MAX_WIDTH - 1);
    end else begin
      w_last = CW'(w_ext - WSZ'(1));
    end
    if (h_ext < HSZ'(2)) begin
      h_last = RW'(1);
    end else if (h_ext > HSZ'(MAX_HEIGHT)) begin
      h_last = RW'(MAX_HEIGHT - 1);
    end else begin
      h_last = RW'(h_ext - HSZ'(1));
    end
  end

  assign last_col = (col_r == w_last);
  assign last_row = (row_r == h_last);
  assign in_acc   = in_valid && !in_stall;

  // Advance raster position
  always_comb begin
    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : row_r + RW'(1);
    end else begin
      col_nxt = col_r + CW'(1);
      row_nxt = row_r;
    end
  end

  // Frame registers and raster counters; a register write restarts the frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= hpi_pkg::RST_FRAME_WIDTH;
      frame_height_r <= hpi_pkg::RST_FRAME_HEIGHT;
      col_r          <= '0;
      row_r          <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        hpi_pkg::REG_FRAME_WIDTH: begin
          frame_width_r <= cfg_data;
          col_r         <= '0;
          row_r         <= '0;
        end
        hpi_pkg::REG_FRAME_HEIGHT: begin
          frame_height_r <= cfg_data;
          col_r          <= '0;
          row_r          <= '0;
        end
        default: ;
      endcase
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Line store: fetch the pixel above and store the new one in one access
  hpi_ram #(
    .WIDTH (hpi_pkg::PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .en    (in_acc),
    .we    (in_acc),
    .addr  (col_r),
    .wdata (in_pixel),
    .rdata (above)
  );

  // Classify which blocks this pixel completes
  always_comb begin
    s2_mask = '0;
    if (s2_row_r != '0 && s2_col_r != '0) begin
      s2_mask = s2_mask | hpi_pkg::KIND_UPPER_LEFT;
      if (s2_last_col_r) begin
        s2_mask = s2_mask | hpi_pkg::KIND_UPPER_RIGHT;
      end
    end
    if (s2_last_row_r && s2_col_r != '0) begin
      s2_mask = s2_mask | hpi_pkg::KIND_LOWER_LEFT;
      if (s2_last_col_r) begin
        s2_mask = s2_mask | hpi_pkg::KIND_LOWER_RIGHT;
      end
    end
  end

  // Pixels without results retire without a queue slot
  assign s2_advance = s2_valid_r && ((s2_mask == '0) || !q_full);
  assign q_push     = s2_valid_r && (s2_mask != '0) && !q_full;
  assign in_stall   = s2_valid_r && !s2_advance;
  assign s2_corner  = s2_valid_r && s2_last_col_r && s2_last_row_r;

  // Hold the pixel while its line-store read completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (in_acc) begin
      s2_valid_r <= 1'b1;
    end else if (s2_advance) begin
      s2_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s2_pix_r      <= in_pixel;
      s2_col_r      <= col_r;
      s2_row_r      <= row_r;
      s2_last_col_r <= last_col;
      s2_last_row_r <= last_row;
    end
  end

  // Left and upper-left neighbors follow retired pixels
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r       <= '0;
      upper_left_r <= '0;
    end else if (s2_advance) begin
      left_r       <= s2_pix_r;
      upper_left_r <= above;
    end
  end

  assign q_quad.pix        = s2_pix_r;
  assign q_quad.above      = above;
  assign q_quad.left       = left_r;
  assign q_quad.upper_left = upper_left_r;
  assign q_mask            = s2_mask;
  assign q_col             = s2_col_r;
  assign q_row             = s2_row_r;

  `HPI_ASSERT_SAME(a_pos_in_frame, 1'b1, col_r <= w_last && row_r <= h_last, "off frame")
  `HPI_ASSERT_SAME(a_corner_full, s2_corner, s2_mask == hpi_pkg::KIND_ALL, "corner short")
  `HPI_ASSERT_SAME(a_push_has_work, q_push, s2_mask != '0, "push without blocks")

endmodule

/* design/hpi_queue.sv */
// Small register FIFO between the front end and the result sequencer.
`include "half_pel_image_interpolator_defines.svh"

module hpi_queue #(
  parameter int WIDTH = 32,
  parameter int DEPTH = hpi_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             not_empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [NW-1:0]    count_r;

  assign full      = (count_r == NW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign rdata     = slot_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + NW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

  `HPI_ASSERT_SAME(a_no_overflow, push, !full, "push into full queue")
  `HPI_ASSERT_SAME(a_no_underflow, pop, not_empty, "pop from empty queue")
  `HPI_ASSERT_SAME(a_count_bound, 1'b1, count_r <= NW'(DEPTH), "queue count beyond depth")

endmodule

/* design/hpi_back.sv */
// Back end: walks the result kinds of each queued pixel and drives the output register.
`include "half_pel_image_interpolator_defines.svh"

module hpi_back #(
  parameter int CW = 10,
  parameter int RW = 10
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_not_empty,
  output logic                              q_pop,
  input  hpi_pkg::pix_quad_t                q_quad,
  input  hpi_pkg::kind_mask_t               q_mask,
  input  logic [CW-1:0]                     q_col,
  input  logic [RW-1:0]                     q_row,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [hpi_pkg::COORD_W-1:0]       out_src_col,
  output logic [hpi_pkg::COORD_W-1:0]       out_src_row,
  output logic [hpi_pkg::PIX_W-1:0]         out_full_pel,
  output logic [hpi_pkg::PIX_W-1:0]         out_half_right,
  output logic [hpi_pkg::PIX_W-1:0]         out_half_down,
  output logic [hpi_pkg::PIX_W-1:0]         out_half_diag,
  output logic                              out_last_of_run,
  output logic                              out_frame_end
);

  logic                      cur_valid_r;
  hpi_pkg::kind_mask_t       cur_mask_r, sel, rest;
  hpi_pkg::pix_quad_t        cur_quad_r;
  logic [CW-1:0]             cur_col_r, col_m1, res_col;
  logic [RW-1:0]             cur_row_r, row_m1, res_row;
  logic                      can_load, emit, need;

  logic [hpi_pkg::PIX_W-1:0] res_full, res_right, res_down, res_diag;
  logic                      res_fend;

  logic                      out_valid_r, out_last_r, out_fend_r;
  logic [hpi_pkg::COORD_W-1:0] out_col_r, out_row_r;
  logic [hpi_pkg::PIX_W-1:0] out_full_r, out_right_r, out_down_r, out_diag_r;

  // Pick the lowest pending kind
  assign sel      = cur_mask_r & (~cur_mask_r + hpi_pkg::kind_mask_t'(1));
  assign rest     = cur_mask_r & ~sel;
  assign can_load = !out_valid_r || !out_stall;
  assign emit     = cur_valid_r && can_load;
  assign need     = !cur_valid_r || (emit && rest == '0);
  assign q_pop    = need && q_not_empty;

  assign col_m1 = cur_col_r - CW'(1);
  assign row_m1 = cur_row_r - RW'(1);

  // Form the half-pel block of the selected kind
  always_comb begin
    res_col   = cur_col_r;
    res_row   = cur_row_r;
    res_full  = cur_quad_r.pix;
    res_right = cur_quad_r.pix;
    res_down  = cur_quad_r.pix;
    res_diag  = cur_quad_r.pix;
    res_fend  = 1'b0;
    case (sel)
      hpi_pkg::KIND_UPPER_LEFT: begin
        res_col   = col_m1;
        res_row   = row_m1;
        res_full  = cur_quad_r.upper_left;
        res_right = hpi_pkg::avg2(cur_quad_r.upper_left, cur_quad_r.above);
        res_down  = hpi_pkg::avg2(cur_quad_r.upper_left, cur_quad_r.left);
        res_diag  = hpi_pkg::avg4(cur_quad_r.upper_left, cur_quad_r.above,
                                  cur_quad_r.left, cur_quad_r.pix);
      end
      hpi_pkg::KIND_UPPER_RIGHT: begin
        res_row   = row_m1;
        res_full  = cur_quad_r.above;
        res_right = cur_quad_r.above;
        res_down  = hpi_pkg::avg2(cur_quad_r.above, cur_quad_r.pix);
        res_diag  = hpi_pkg::avg2(cur_quad_r.above, cur_quad_r.pix);
      end
      hpi_pkg::KIND_LOWER_LEFT: begin
        res_col   = col_m1;
        res_full  = cur_quad_r.left;
        res_right = hpi_pkg::avg2(cur_quad_r.left, cur_quad_r.pix);
        res_down  = cur_quad_r.left;
        res_diag  = hpi_pkg::avg2(cur_quad_r.left, cur_quad_r.pix);
      end
      hpi_pkg::KIND_LOWER_RIGHT: begin
        res_fend  = 1'b1;
      end
      default: ;
    endcase
  end

  // Load the next pixel or drop the kind just sent
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
    end else if (q_pop) begin
      cur_valid_r <= 1'b1;
    end else if (emit && rest == '0) begin
      cur_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_mask_r <= q_mask;
      cur_quad_r <= q_quad;
      cur_col_r  <= q_col;
      cur_row_r  <= q_row;
    end else if (emit) begin
      cur_mask_r <= rest;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_col_r   <= hpi_pkg::COORD_W'(res_col);
      out_row_r   <= hpi_pkg::COORD_W'(res_row);
      out_full_r  <= res_full;
      out_right_r <= res_right;
      out_down_r  <= res_down;
      out_diag_r  <= res_diag;
      out_last_r  <= (rest == '0);
      out_fend_r  <= res_fend;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_src_col     = out_col_r;
  assign out_src_row     = out_row_r;
  assign out_full_pel    = out_full_r;
  assign out_half_right  = out_right_r;
  assign out_half_down   = out_down_r;
  assign out_half_diag   = out_diag_r;
  assign out_last_of_run = out_last_r;
  assign out_frame_end   = out_fend_r;

  `HPI_ASSERT_SAME(a_cur_has_work, cur_valid_r, cur_mask_r != '0, "no pending kind")
  `HPI_ASSERT_SAME(a_fend_is_last, out_valid_r && out_fend_r, out_last_r, "frame end not last")
  `HPI_ASSERT_NEXT(a_out_hold, out_valid_r && out_stall, out_valid_r, "stalled result dropped")

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the half-pel image interpolator.
`timescale 1ns / 100ps

module testbench;

  localparam int CLK_HALF      = 1;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 20;
  localparam int CYCLE_LIMIT   = 3000000;
  localparam int RANDOM_ITEMS  = 120;
  localparam int RESET_ITEMS   = 24;
  localparam int OVERSIZE_ITEMS = 16;

  typedef struct packed {
    logic [hpi_pkg::COORD_W-1:0] src_col;
    logic [hpi_pkg::COORD_W-1:0] src_row;
    logic [hpi_pkg::PIX_W-1:0]   full_pel;
    logic [hpi_pkg::PIX_W-1:0]   half_right;
    logic [hpi_pkg::PIX_W-1:0]   half_down;
    logic [hpi_pkg::PIX_W-1:0]   half_diag;
    logic                        last_of_run;
    logic                        frame_end;
  } block_t;

  typedef enum logic [1:0] {ROW_WIDTH, ROW_HEIGHT, ROW_PIXEL} stim_kind_t;

  typedef struct {
    stim_kind_t                kind;
    logic [hpi_pkg::CFG_W-1:0] value;
    bit                        typed;
    int unsigned               corner_col;
    int unsigned               corner_row;
  } stim_row_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_we = 1'b0;
  logic [hpi_pkg::CFG_IDX_W-1:0] cfg_index = hpi_pkg::REG_FRAME_WIDTH;
  logic [hpi_pkg::CFG_W-1:0]     cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [hpi_pkg::PIX_W-1:0]     in_pixel = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [hpi_pkg::COORD_W-1:0]   out_src_col;
  logic [hpi_pkg::COORD_W-1:0]   out_src_row;
  logic [hpi_pkg::PIX_W-1:0]     out_full_pel;
  logic [hpi_pkg::PIX_W-1:0]     out_half_right;
  logic [hpi_pkg::PIX_W-1:0]     out_half_down;
  logic [hpi_pkg::PIX_W-1:0]     out_half_diag;
  logic                          out_last_of_run;
  logic                          out_frame_end;

  // Blocks predicted but not yet seen at the output
  block_t    pending_blocks[$];
  stim_row_t stim_rows[$];
  int        mismatch_count = 0;
  int        cycle_count = 0;
  int        stall_left = 0;
  bit        send_idle = 1'b1;
  bit        stall_idle = 1'b1;

  // Interpolator image of the block
  logic [hpi_pkg::PIX_W-1:0] line_mem [hpi_pkg::DEF_MAX_WIDTH];
  logic [hpi_pkg::PIX_W-1:0] prev_left = '0;
  logic [hpi_pkg::PIX_W-1:0] prev_upper_left = '0;
  int unsigned               col_pos = 0;
  int unsigned               row_pos = 0;
  logic [hpi_pkg::CFG_W-1:0] width_reg = hpi_pkg::RST_FRAME_WIDTH;
  logic [hpi_pkg::CFG_W-1:0] height_reg = hpi_pkg::RST_FRAME_HEIGHT;

  half_pel_image_interpolator u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_pixel        (in_pixel),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_src_col     (out_src_col),
    .out_src_row     (out_src_row),
    .out_full_pel    (out_full_pel),
    .out_half_right  (out_half_right),
    .out_half_down   (out_half_down),
    .out_half_diag   (out_half_diag),
    .out_last_of_run (out_last_of_run),
    .out_frame_end   (out_frame_end)
  );

  always #CLK_HALF clk = ~clk;

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    foreach (line_mem[i]) line_mem[i] = '0;
  end

  // Sizes below two act as two, sizes above the limit act as the limit
  function automatic int unsigned eff_dim(input logic [hpi_pkg::CFG_W-1:0] v,
                                          input int unsigned limit);
    if (v < 2) return 2;
    if (v > limit) return limit;
    return 32'(v);
  endfunction

  function automatic logic [hpi_pkg::PIX_W-1:0] mean2(input int unsigned a,
                                                      input int unsigned b);
    return hpi_pkg::PIX_W'((a + b + 1) >> 1);
  endfunction

  function automatic logic [hpi_pkg::PIX_W-1:0] mean4(input int unsigned a,
                                                      input int unsigned b,
                                                      input int unsigned c,
                                                      input int unsigned d);
    return hpi_pkg::PIX_W'((a + b + c + d + 2) >> 2);
  endfunction

  function automatic block_t make_block(input int unsigned col, input int unsigned row,
                                        input logic [hpi_pkg::PIX_W-1:0] f,
                                        input logic [hpi_pkg::PIX_W-1:0] rt,
                                        input logic [hpi_pkg::PIX_W-1:0] dn,
                                        input logic [hpi_pkg::PIX_W-1:0] dg,
                                        input logic fend);
    block_t b;
    b.src_col     = hpi_pkg::COORD_W'(col);
    b.src_row     = hpi_pkg::COORD_W'(row);
    b.full_pel    = f;
    b.half_right  = rt;
    b.half_down   = dn;
    b.half_diag   = dg;
    b.last_of_run = 1'b0;
    b.frame_end   = fend;
    return b;
  endfunction

  // Advance the raster position by one pixel and queue the blocks it completes
  task automatic interp_pixel(input logic [hpi_pkg::PIX_W-1:0] p);
    block_t                    blk [4];
    int                        n;
    int unsigned               w, h, c, r;
    logic [hpi_pkg::PIX_W-1:0] above, ul, lf, dn, rt;
    logic                      lc, lr;
    n = 0;
    w = eff_dim(width_reg, hpi_pkg::DEF_MAX_WIDTH);
    h = eff_dim(height_reg, hpi_pkg::DEF_MAX_HEIGHT);
    c = col_pos;
    r = row_pos;
    if (c >= w) c = w - 1;
    if (r >= h) r = h - 1;
    lc = (c == w - 1);
    lr = (r == h - 1);
    above = line_mem[c];
    ul = prev_upper_left;
    lf = prev_left;
    // Upper row: block up-left, plus the block straight up at the row end
    if (r >= 1 && c >= 1) begin
      blk[n] = make_block(c - 1, r - 1, ul, mean2(ul, above), mean2(ul, lf),
                          mean4(ul, above, lf, p), 1'b0);
      n++;
      if (lc) begin
        dn = mean2(above, p);
        blk[n] = make_block(c, r - 1, above, above, dn, dn, 1'b0);
        n++;
      end
    end
    // Last row: lower pair copies the upper pair, corner is the pixel itself
    if (lr && c >= 1) begin
      rt = mean2(lf, p);
      blk[n] = make_block(c - 1, r, lf, rt, lf, rt, 1'b0);
      n++;
      if (lc) begin
        blk[n] = make_block(c, r, p, p, p, p, 1'b1);
        n++;
      end
    end
    if (n > 0) blk[n-1].last_of_run = 1'b1;
    for (int i = 0; i < n; i++) pending_blocks.push_back(blk[i]);
    prev_upper_left = above;
    line_mem[c] = p;
    prev_left = p;
    if (lc) begin
      col_pos = 0;
      row_pos = lr ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
  endtask

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [hpi_pkg::COORD_W-1:0] got,
                             input logic [hpi_pkg::COORD_W-1:0] want, input block_t ref_blk);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d want %0d (block col %0d row %0d)", name, got,
                                want, ref_blk.src_col, ref_blk.src_row));
  endtask

  // Compare one output transfer with the oldest predicted block
  task automatic check_block();
    block_t want;
    if (pending_blocks.size() == 0) begin
      report_mismatch($sformatf("unexpected block col %0d row %0d", out_src_col,
                                out_src_row));
      return;
    end
    want = pending_blocks.pop_front();
    check_field("src_col", out_src_col, want.src_col, want);
    check_field("src_row", out_src_row, want.src_row, want);
    check_field("full_pel", out_full_pel, want.full_pel, want);
    check_field("half_right", out_half_right, want.half_right, want);
    check_field("half_down", out_half_down, want.half_down, want);
    check_field("half_diag", out_half_diag, want.half_diag, want);
    check_field("last_of_run", out_last_of_run, want.last_of_run, want);
    check_field("frame_end", out_frame_end, want.frame_end, want);
  endtask

  // Mostly short idle runs, now and then a long one
  function automatic int idle_len();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 30);
  endfunction

  function automatic logic [hpi_pkg::PIX_W-1:0] rand_pixel();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) return '1;
    return hpi_pkg::PIX_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [hpi_pkg::CFG_W-1:0] rand_dim();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return hpi_pkg::CFG_W'($urandom_range(2, 8));
    if (r < 80) return hpi_pkg::CFG_W'($urandom_range(0, 1));
    if (r < 92) return hpi_pkg::CFG_W'($urandom_range(9, 40));
    return hpi_pkg::CFG_W'($urandom_range(41, 2047));
  endfunction

  // Check accepted results, then pick the stall for the next cycle
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_block();
    if (stall_left > 0) stall_left--;
    else if (stall_idle && $urandom_range(0, 99) < 30) stall_left = idle_len();
    out_stall <= (stall_left > 0);
  end

  // Offer one pixel, hold it until the transfer, then predict
  task automatic send_pixel(input logic [hpi_pkg::PIX_W-1:0] p);
    int gap;
    gap = (send_idle && $urandom_range(0, 99) < 35) ? idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel <= p;
    do @(posedge clk); while (in_stall);
    interp_pixel(p);
  endtask

  // Drop valid and let the block drain, including pixels that yield no block
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_blocks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register writes restart the frame
  task automatic write_reg(input logic [hpi_pkg::CFG_IDX_W-1:0] idx,
                           input logic [hpi_pkg::CFG_W-1:0] val);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == hpi_pkg::REG_FRAME_WIDTH) width_reg = val;
    else height_reg = val;
    col_pos = 0;
    row_pos = 0;
    @(posedge clk);
  endtask

  function automatic void add_row(input stim_kind_t kind, input int unsigned value,
                                  input bit typed = 1'b0, input int unsigned cc = 0,
                                  input int unsigned cr = 0);
    stim_row_t row;
    row.kind = kind;
    row.value = hpi_pkg::CFG_W'(value);
    row.typed = typed;
    row.corner_col = cc;
    row.corner_row = cr;
    stim_rows.push_back(row);
  endfunction

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** half_pel_image_interpolator: FAILED **");
    $finish;
  end

  initial begin
    block_t                    corner;
    int unsigned               n_items, rand_count, eff_w, eff_h, pick;
    logic [hpi_pkg::PIX_W-1:0] v;

    do @(posedge clk); while (!rst_n);

    // Reset geometry: part of the first row, which yields no block
    repeat (RESET_ITEMS) send_pixel(rand_pixel());

    // Flat black and flat white 2x2 frames
    add_row(ROW_WIDTH, 2);
    add_row(ROW_HEIGHT, 2);
    repeat (3) add_row(ROW_PIXEL, 0);
    add_row(ROW_PIXEL, 0, 1'b1, 1, 1);
    repeat (3) add_row(ROW_PIXEL, 255);
    add_row(ROW_PIXEL, 255, 1'b1, 1, 1);
    // Checkerboard for rounding
    add_row(ROW_PIXEL, 255);
    add_row(ROW_PIXEL, 0);
    add_row(ROW_PIXEL, 0);
    add_row(ROW_PIXEL, 255, 1'b1, 1, 1);
    // Sizes below two act as two
    add_row(ROW_WIDTH, 0);
    add_row(ROW_HEIGHT, 1);
    add_row(ROW_PIXEL, 1);
    add_row(ROW_PIXEL, 2);
    add_row(ROW_PIXEL, 3);
    add_row(ROW_PIXEL, 200, 1'b1, 1, 1);
    // 3x3: interior, last column, last row and corner
    add_row(ROW_WIDTH, 3);
    add_row(ROW_HEIGHT, 3);
    add_row(ROW_PIXEL, 10);
    add_row(ROW_PIXEL, 255);
    add_row(ROW_PIXEL, 0);
    add_row(ROW_PIXEL, 37);
    add_row(ROW_PIXEL, 128);
    add_row(ROW_PIXEL, 91);
    add_row(ROW_PIXEL, 254);
    add_row(ROW_PIXEL, 1);
    add_row(ROW_PIXEL, 66, 1'b1, 2, 2);

    foreach (stim_rows[i]) begin
      case (stim_rows[i].kind)
        ROW_WIDTH: write_reg(hpi_pkg::REG_FRAME_WIDTH, stim_rows[i].value);
        ROW_HEIGHT: write_reg(hpi_pkg::REG_FRAME_HEIGHT, stim_rows[i].value);
        default: begin
          v = stim_rows[i].value[hpi_pkg::PIX_W-1:0];
          send_pixel(v);
          // Swap in the hand-written corner block
          if (stim_rows[i].typed) begin
            corner = make_block(stim_rows[i].corner_col, stim_rows[i].corner_row,
                                v, v, v, v, 1'b1);
            corner.last_of_run = 1'b1;
            void'(pending_blocks.pop_back());
            pending_blocks.push_back(corner);
          end
        end
      endcase
    end

    // Oversized width, then oversized height, a few pixels each
    write_reg(hpi_pkg::REG_FRAME_WIDTH, 11'd2047);
    write_reg(hpi_pkg::REG_FRAME_HEIGHT, 11'd2);
    repeat (OVERSIZE_ITEMS) send_pixel(rand_pixel());
    write_reg(hpi_pkg::REG_FRAME_WIDTH, 11'd2);
    write_reg(hpi_pkg::REG_FRAME_HEIGHT, 11'd2047);
    repeat (OVERSIZE_ITEMS) send_pixel(rand_pixel());

    // Random phases: mostly whole small frames, some partial ones
    rand_count = 0;
    while (rand_count < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 3);
      if (pick != 1) write_reg(hpi_pkg::REG_FRAME_WIDTH, rand_dim());
      if (pick != 0) write_reg(hpi_pkg::REG_FRAME_HEIGHT, rand_dim());
      send_idle = ($urandom_range(0, 3) != 0);
      stall_idle = ($urandom_range(0, 3) != 0);
      eff_w = eff_dim(width_reg, hpi_pkg::DEF_MAX_WIDTH);
      eff_h = eff_dim(height_reg, hpi_pkg::DEF_MAX_HEIGHT);
      if (eff_w * eff_h <= 80 && $urandom_range(0, 3) != 0)
        n_items = eff_w * eff_h * $urandom_range(1, 2) + $urandom_range(0, 2);
      else
        n_items = $urandom_range(1, 50);
      repeat (n_items) send_pixel(rand_pixel());
      rand_count += n_items;
    end

    // Drain and settle
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** half_pel_image_interpolator: PASSED **");
    end else begin
      $display("** half_pel_image_interpolator: FAILED **");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+design
design/hpi_pkg.sv
design/hpi_ram.sv
design/hpi_front.sv
design/hpi_queue.sv
design/hpi_back.sv
design/half_pel_image_interpolator.sv
dv/testbench.sv
